// ===== hdl/hto_pkg.sv =====
`default_nettype none

package hto_pkg;

    // Widths of the configuration registers and the item fields.
    localparam int FUND_W      = 15;
    localparam int RATE_W      = 18;
    localparam int COUNT_W     = 4;
    localparam int WIDE_W      = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int AMP_W       = 16;
    localparam int PHASE_W     = 16;
    localparam int FIELD_SEL_W = 3;
    localparam int SAMPLE_W    = 19;
    localparam int ACTIVE_W    = 4;
    localparam int ROM_W       = 16;

    // Product of an interpolated table value and an amplitude.
    localparam int TERM_W = 34;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_FUNDAMENTAL     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HARMONIC_COUNT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDES_LOW  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDES_HIGH = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASES_LOW      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASES_HIGH     = 3'd6;

    // Register values after reset.
    localparam logic [FUND_W-1:0]  RST_FUNDAMENTAL    = 15'd440;
    localparam logic [RATE_W-1:0]  RST_SAMPLE_RATE    = 18'd48000;
    localparam logic [COUNT_W-1:0] RST_HARMONIC_COUNT = 4'd1;
    localparam logic [WIDE_W-1:0]  RST_AMPLITUDES_LOW = 64'd16384;

    // Default module parameters.
    localparam int DEF_TABLE_LENGTH  = 1024;
    localparam int DEF_MAX_HARMONICS = 8;
    localparam int DEF_FRACTION_BITS = 16;

    // Highest audible harmonic frequency in hertz.
    localparam logic [RATE_W-1:0] FREQ_LIMIT = 18'd20000;

    // Saturation bounds of the output sample.
    localparam int SAMPLE_MAX = 262143;
    localparam int SAMPLE_MIN = -262144;

    // Control of the shared interpolate and multiply unit.
    typedef struct packed {
        logic valid;
        logic clear;
    } t_mac_ctrl;

endpackage

`default_nettype wire

// ===== hdl/hto_in_if.sv =====
`default_nettype none

interface hto_in_if
    import hto_pkg::*;
();
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

// ===== hdl/hto_out_if.sv =====
`default_nettype none

interface hto_out_if
    import hto_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic [ACTIVE_W-1:0]        active_harmonics;

    modport source (output valid, output sample, output active_harmonics, input ready);
    modport sink (input valid, input sample, input active_harmonics, output ready);
endinterface

`default_nettype wire

// ===== hdl/hto_cell.sv =====
`default_nettype none

// One harmonic's state in the ring: enable flag, phase accumulator and phase step.
// On a shift it takes over the state of its neighbor.
module hto_cell
    import hto_pkg::*;
#(
    parameter int ACC_W = 26
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_shift,
    input  wire              i_on,
    input  wire  [ACC_W-1:0] i_acc,
    input  wire  [ACC_W-1:0] i_inc,
    output logic             o_on,
    output logic [ACC_W-1:0] o_acc,
    output logic [ACC_W-1:0] o_inc
);

    logic             r_on;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] r_inc;

    // The state moves one place along the ring on each shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on  <= 1'b0;
            r_acc <= '0;
            r_inc <= '0;
        end else if (i_shift) begin
            r_on  <= i_on;
            r_acc <= i_acc;
            r_inc <= i_inc;
        end
    end

    assign o_on  = r_on;
    assign o_acc = r_acc;
    assign o_inc = r_inc;

endmodule

`default_nettype wire

// ===== hdl/hto_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in Q_W bits and that the divisor is not zero.
module hto_div
    import hto_pkg::*;
#(
    parameter int NUM_W = 57,
    parameter int Q_W   = 26
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire  [NUM_W-1:0] i_num,
    input  wire  [RATE_W-1:0] i_den,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quo
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [RATE_W-1:0] r_rem;
    logic [RATE_W-1:0] r_den;
    logic [Q_W-1:0]    r_quo;

    logic [RATE_W:0]   w_trial;
    logic [RATE_W:0]   w_diff;
    logic              w_fits;

    // Bring down the next numerator bit and try to subtract the divisor.
    assign w_trial = {r_rem, r_quo[Q_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    // Control: a start loads the operands, then Q_W steps follow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient bits shift in where the numerator bits leave.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= RATE_W'(i_num >> Q_W);
            r_quo <= i_num[Q_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[RATE_W-1:0] : w_trial[RATE_W-1:0];
            r_quo <= {r_quo[Q_W-2:0], w_fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ===== hdl/hto_mac.sv =====
`default_nettype none

// Cosine table lookup, linear interpolation, amplitude scaling and the running
// sum. Three register stages, then the accumulator.
module hto_mac
    import hto_pkg::*;
#(
    parameter int TABLE_LENGTH  = 1024,
    parameter int FRACTION_BITS = 16,
    parameter int SUM_W         = 38
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  t_mac_ctrl                     i_ctrl,
    input  wire  [$clog2(TABLE_LENGTH)+FRACTION_BITS-1:0] i_acc,
    input  wire  signed [AMP_W-1:0]       i_amp,
    output logic signed [SUM_W-1:0]       o_sum,
    output logic                          o_idle
);

    localparam int IDX_W  = $clog2(TABLE_LENGTH);
    localparam int ACC_W  = IDX_W + FRACTION_BITS;
    localparam int DIFF_W = ROM_W + 1;
    localparam int PROD_W = DIFF_W + FRACTION_BITS + 1;
    localparam int VAL_W  = PROD_W - FRACTION_BITS;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // One minus a Taylor term, clamped at zero.
    function automatic logic [63:0] one_minus(input logic [63:0] term);
        return (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
    endfunction

    // Cosine of u quarter turns in Q30, Horner form of degree fourteen.
    function automatic logic [63:0] quarter_cos(input logic [63:0] u);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] r;
        x  = (u * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        r  = Q30_ONE;
        r  = one_minus(((x2 * r) >> 30) / 64'd182);
        r  = one_minus(((x2 * r) >> 30) / 64'd132);
        r  = one_minus(((x2 * r) >> 30) / 64'd90);
        r  = one_minus(((x2 * r) >> 30) / 64'd56);
        r  = one_minus(((x2 * r) >> 30) / 64'd30);
        r  = one_minus(((x2 * r) >> 30) / 64'd12);
        r  = one_minus(((x2 * r) >> 30) / 64'd2);
        return r;
    endfunction

    // Q1.15 table entry, folded into the first quadrant and signed back.
    function automatic logic signed [ROM_W-1:0] cos_entry(input int unsigned idx);
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] arg;
        logic [63:0] c;
        logic [63:0] mag;
        logic [1:0]  quad;
        t    = ((64'(idx) << 32) / 64'(TABLE_LENGTH)) & 64'hFFFF_FFFF;
        quad = t[31:30];
        u    = {34'd0, t[29:0]};
        arg  = (quad == 2'd1 || quad == 2'd3) ? Q30_ONE - u : u;
        c    = quarter_cos(arg);
        mag  = (c * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        return ROM_W'((quad == 2'd1 || quad == 2'd2) ? 64'd0 - mag : mag);
    endfunction

    // Cosine table, fixed at elaboration.
    logic signed [ROM_W-1:0] w_rom [TABLE_LENGTH];

    for (genvar g = 0; g < TABLE_LENGTH; g++) begin : g_rom
        localparam logic signed [ROM_W-1:0] ROM_VAL = cos_entry(g);
        assign w_rom[g] = ROM_VAL;
    end

    logic [IDX_W-1:0] w_i0;
    logic [IDX_W-1:0] w_i1;

    // Neighboring entries; the one after the last wraps to entry zero.
    assign w_i0 = i_acc[ACC_W-1:FRACTION_BITS];
    assign w_i1 = (w_i0 == IDX_W'(TABLE_LENGTH - 1)) ? '0 : w_i0 + 1'b1;

    logic                         r_val1;
    logic signed [ROM_W-1:0]      r_v0;
    logic signed [ROM_W-1:0]      r_v1;
    logic [FRACTION_BITS-1:0]     r_frac1;
    logic signed [AMP_W-1:0]      r_amp1;

    // Stage one: registered table reads.
    always_ff @(posedge i_clk) begin
        r_v0    <= w_rom[w_i0];
        r_v1    <= w_rom[w_i1];
        r_frac1 <= i_acc[FRACTION_BITS-1:0];
        r_amp1  <= i_amp;
    end

    logic signed [DIFF_W-1:0]     w_diff;
    logic signed [PROD_W-1:0]     w_prod;
    logic                         r_val2;
    logic signed [PROD_W-1:0]     r_prod2;
    logic signed [ROM_W-1:0]      r_v0_2;
    logic signed [AMP_W-1:0]      r_amp2;

    // Stage two: slope times the fraction of the step.
    assign w_diff = $signed({r_v1[ROM_W-1], r_v1}) - $signed({r_v0[ROM_W-1], r_v0});
    assign w_prod = w_diff * $signed({1'b0, r_frac1});

    always_ff @(posedge i_clk) begin
        r_prod2 <= w_prod;
        r_v0_2  <= r_v0;
        r_amp2  <= r_amp1;
    end

    logic signed [VAL_W-1:0]      w_val;
    logic signed [TERM_W-1:0]     w_term;
    logic                         r_val3;
    logic signed [TERM_W-1:0]     r_term3;

    // Stage three: the upper product bits are the floored step, then scale.
    assign w_val  = $signed(VAL_W'($signed(r_v0_2))) + $signed(r_prod2[PROD_W-1:FRACTION_BITS]);
    assign w_term = w_val * r_amp2;

    always_ff @(posedge i_clk) begin
        r_term3 <= w_term;
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val1 <= 1'b0;
            r_val2 <= 1'b0;
            r_val3 <= 1'b0;
        end else begin
            r_val1 <= i_ctrl.valid;
            r_val2 <= r_val1;
            r_val3 <= r_val2;
        end
    end

    logic signed [SUM_W-1:0] r_sum;

    // Running sum of the active harmonics at full precision.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctrl.clear) begin
            r_sum <= '0;
        end else if (r_val3) begin
            r_sum <= r_sum + SUM_W'(r_term3);
        end
    end

    assign o_sum  = r_sum;
    assign o_idle = !(r_val1 || r_val2 || r_val3);

endmodule

`default_nettype wire

// ===== hdl/harmonic_table_oscillator.sv =====
// Flow: an accepted item goes through an optional reload, one turn of the ring over all
// MAX_HARMONICS cells, a drain of the multiply pipeline and the output register; the
// drain ends sooner when the last harmonics are skipped; an output stall holds the result.
// A reload runs the serial divider (Q = log2(TABLE_LENGTH) + FRACTION_BITS quotient bits)
// for the phase step of each active harmonic. Throughput: one item at a time.
// Reset: synchronous, active low; the first item reloads all phases; the table is constant.
`default_nettype none

module harmonic_table_oscillator
    import hto_pkg::*;
#(
    parameter int TABLE_LENGTH  = DEF_TABLE_LENGTH,
    parameter int MAX_HARMONICS = DEF_MAX_HARMONICS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire  [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire  [WIDE_W-1:0]      i_cfg_data,
    hto_in_if.sink                 i_in,
    hto_out_if.source              o_out
);

    localparam int IDX_W   = $clog2(TABLE_LENGTH);
    localparam int ACC_W   = IDX_W + FRACTION_BITS;
    localparam int TL_W    = $clog2(TABLE_LENGTH + 1);
    localparam int NUM_W   = FUND_W + TL_W + FRACTION_BITS;
    localparam int LOADP_W = PHASE_W + TL_W + FRACTION_BITS;
    localparam int CNT_W   = $clog2(MAX_HARMONICS + 1);
    localparam int SUM_W   = TERM_W + $clog2(MAX_HARMONICS) + 1;
    localparam int SH_W    = SUM_W - 15;

    localparam logic [ACC_W:0] ACC_MOD = (ACC_W + 1)'(TABLE_LENGTH) << FRACTION_BITS;
    localparam logic signed [SH_W-1:0] SH_MAX = SH_W'(SAMPLE_MAX);
    localparam logic signed [SH_W-1:0] SH_MIN = SH_W'(SAMPLE_MIN);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_LOAD_CHECK = 3'd1;
    localparam logic [2:0] S_LOAD_DIV   = 3'd2;
    localparam logic [2:0] S_RUN        = 3'd3;
    localparam logic [2:0] S_DRAIN      = 3'd4;

    // 16-bit field of a harmonic from a pair of packed registers.
    function automatic logic [15:0] field16(input logic [WIDE_W-1:0] lo,
                                            input logic [WIDE_W-1:0] hi,
                                            input logic [FIELD_SEL_W-1:0] sel);
        logic [WIDE_W-1:0] w;
        w = sel[2] ? hi : lo;
        return w[16*sel[1:0] +: 16];
    endfunction

    logic [FUND_W-1:0]  r_fund;
    logic [RATE_W-1:0]  r_rate;
    logic [COUNT_W-1:0] r_count;
    logic [WIDE_W-1:0]  r_amp_low;
    logic [WIDE_W-1:0]  r_amp_high;
    logic [WIDE_W-1:0]  r_phase_low;
    logic [WIDE_W-1:0]  r_phase_high;
    logic               r_needs_load;

    logic [2:0]         r_state;
    logic [CNT_W-1:0]   r_k;
    logic [RATE_W-1:0]  r_freq;
    logic [CNT_W-1:0]   r_active_cnt;
    logic               r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic [ACTIVE_W-1:0] r_out_active;

    logic               w_in_accept;
    logic               w_reload;
    logic               w_last;
    logic               w_active;
    logic [COUNT_W-1:0] w_cnt_lim;
    logic               w_out_write;
    logic               w_div_start;
    logic               w_div_done;
    logic [ACC_W-1:0]   w_div_quo;
    logic [NUM_W-1:0]   w_num;
    logic [LOADP_W-1:0] w_pload_full;
    logic [ACC_W-1:0]   w_pload;
    logic [ACC_W:0]     w_acc_sum;
    logic [ACC_W-1:0]   w_adv;
    logic signed [AMP_W-1:0] w_amp;
    logic signed [SUM_W-1:0] w_sum;
    logic               w_mac_idle;
    logic signed [SH_W-1:0]  w_shifted;
    logic signed [SAMPLE_W-1:0] w_sat;
    t_mac_ctrl          w_mac_ctrl;

    logic               w_shift;
    logic               n_tail_on;
    logic [ACC_W-1:0]   n_tail_acc;
    logic [ACC_W-1:0]   n_tail_inc;

    logic               w_on  [MAX_HARMONICS];
    logic [ACC_W-1:0]   w_acc [MAX_HARMONICS];
    logic [ACC_W-1:0]   w_inc [MAX_HARMONICS];

    // Configuration registers; any known write forces a reload on the next item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fund       <= RST_FUNDAMENTAL;
            r_rate       <= RST_SAMPLE_RATE;
            r_count      <= RST_HARMONIC_COUNT;
            r_amp_low    <= RST_AMPLITUDES_LOW;
            r_amp_high   <= '0;
            r_phase_low  <= '0;
            r_phase_high <= '0;
            r_needs_load <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FUNDAMENTAL:     r_fund       <= i_cfg_data[FUND_W-1:0];
                REG_SAMPLE_RATE:     r_rate       <= i_cfg_data[RATE_W-1:0];
                REG_HARMONIC_COUNT:  r_count      <= i_cfg_data[COUNT_W-1:0];
                REG_AMPLITUDES_LOW:  r_amp_low    <= i_cfg_data;
                REG_AMPLITUDES_HIGH: r_amp_high   <= i_cfg_data;
                REG_PHASES_LOW:      r_phase_low  <= i_cfg_data;
                REG_PHASES_HIGH:     r_phase_high <= i_cfg_data;
                default: begin
                end
            endcase
            if (i_cfg_index <= REG_PHASES_HIGH) begin
                r_needs_load <= 1'b1;
            end
        end else if (w_in_accept && w_reload) begin
            r_needs_load <= 1'b0;
        end
    end

    // Handshake and sequencing conditions.
    assign w_in_accept = i_in.valid && i_in.ready;
    assign w_reload    = i_in.restart || r_needs_load;
    assign w_last      = (r_k == CNT_W'(MAX_HARMONICS - 1));
    assign w_out_write = (r_state == S_DRAIN) && w_mac_idle && (!r_out_valid || o_out.ready);

    // A harmonic is kept when it is in the count, below half the sample rate and not above the audible limit.
    assign w_cnt_lim = (r_count > COUNT_W'(MAX_HARMONICS)) ? COUNT_W'(MAX_HARMONICS) : r_count;
    assign w_active  = (COUNT_W'(r_k) < w_cnt_lim) && (r_freq < {1'b0, r_rate[RATE_W-1:1]})
                       && (r_freq <= FREQ_LIMIT);

    // Phase step numerator and start phase in accumulator units.
    assign w_num        = NUM_W'(NUM_W'(r_freq[FUND_W-1:0]) * NUM_W'(TABLE_LENGTH))
                          << FRACTION_BITS;
    assign w_pload_full = (LOADP_W'(field16(r_phase_low, r_phase_high, FIELD_SEL_W'(r_k)))
                          * LOADP_W'(TABLE_LENGTH)) << FRACTION_BITS;
    assign w_pload      = ACC_W'(w_pload_full >> PHASE_W);
    assign w_div_start  = (r_state == S_LOAD_CHECK) && w_active;

    hto_div #(
        .NUM_W (NUM_W),
        .Q_W   (ACC_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_rate),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // Phase advance of the harmonic at the head of the ring, wrapping once.
    assign w_acc_sum = {1'b0, w_acc[0]} + {1'b0, w_inc[0]};
    assign w_adv     = ACC_W'((w_acc_sum >= ACC_MOD) ? w_acc_sum - ACC_MOD : w_acc_sum);

    // What enters the tail of the ring: loaded state, an off cell for a skipped harmonic, or the advanced head.
    always_comb begin
        w_shift    = 1'b0;
        n_tail_on  = 1'b0;
        n_tail_acc = '0;
        n_tail_inc = '0;
        unique case (r_state)
            S_LOAD_CHECK: begin
                w_shift = !w_active;
            end
            S_LOAD_DIV: begin
                w_shift    = w_div_done;
                n_tail_on  = 1'b1;
                n_tail_acc = w_pload;
                n_tail_inc = w_div_quo;
            end
            S_RUN: begin
                w_shift    = 1'b1;
                n_tail_on  = w_on[0];
                n_tail_acc = w_adv;
                n_tail_inc = w_inc[0];
            end
            default: begin
                w_shift = 1'b0;
            end
        endcase
    end

    // Ring of harmonic cells; cell zero is the head that feeds the datapath.
    for (genvar g = 0; g < MAX_HARMONICS; g++) begin : g_cell
        if (g == MAX_HARMONICS - 1) begin : g_tail
            hto_cell #(
                .ACC_W (ACC_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_on    (n_tail_on),
                .i_acc   (n_tail_acc),
                .i_inc   (n_tail_inc),
                .o_on    (w_on[g]),
                .o_acc   (w_acc[g]),
                .o_inc   (w_inc[g])
            );
        end else begin : g_link
            hto_cell #(
                .ACC_W (ACC_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_on    (w_on[g+1]),
                .i_acc   (w_acc[g+1]),
                .i_inc   (w_inc[g+1]),
                .o_on    (w_on[g]),
                .o_acc   (w_acc[g]),
                .o_inc   (w_inc[g])
            );
        end
    end

    // Datapath control: the sum is cleared whenever no sample is under way.
    assign w_amp            = $signed(field16(r_amp_low, r_amp_high, FIELD_SEL_W'(r_k)));
    assign w_mac_ctrl.valid = (r_state == S_RUN) && w_on[0];
    assign w_mac_ctrl.clear = (r_state != S_RUN) && (r_state != S_DRAIN);

    hto_mac #(
        .TABLE_LENGTH  (TABLE_LENGTH),
        .FRACTION_BITS (FRACTION_BITS),
        .SUM_W         (SUM_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_mac_ctrl),
        .i_acc   (w_acc[0]),
        .i_amp   (w_amp),
        .o_sum   (w_sum),
        .o_idle  (w_mac_idle)
    );

    // Floor the sum to Q4.15 and saturate to the sample range.
    assign w_shifted = w_sum[SUM_W-1:15];
    always_comb begin
        priority if (w_shifted > SH_MAX) begin
            w_sat = SAMPLE_W'(SAMPLE_MAX);
        end else if (w_shifted < SH_MIN) begin
            w_sat = SAMPLE_W'(SAMPLE_MIN);
        end else begin
            w_sat = w_shifted[SAMPLE_W-1:0];
        end
    end

    // Sequencer: optional reload, one turn of the ring, drain, then the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_k          <= '0;
            r_freq       <= '0;
            r_active_cnt <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_out_write) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_k <= '0;
                        if (w_reload) begin
                            r_freq       <= RATE_W'(r_fund);
                            r_active_cnt <= '0;
                            r_state      <= S_LOAD_CHECK;
                        end else begin
                            r_state <= S_RUN;
                        end
                    end
                end
                S_LOAD_CHECK: begin
                    if (w_active) begin
                        r_state <= S_LOAD_DIV;
                    end else begin
                        r_freq <= r_freq + RATE_W'(r_fund);
                        if (w_last) begin
                            r_k     <= '0;
                            r_state <= S_RUN;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_LOAD_DIV: begin
                    if (w_div_done) begin
                        r_active_cnt <= r_active_cnt + 1'b1;
                        r_freq       <= r_freq + RATE_W'(r_fund);
                        if (w_last) begin
                            r_k     <= '0;
                            r_state <= S_RUN;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_LOAD_CHECK;
                        end
                    end
                end
                S_RUN: begin
                    if (w_last) begin
                        r_k     <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (w_out_write) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register holds the result until it is taken.
    always_ff @(posedge i_clk) begin
        if (w_out_write) begin
            r_out_sample <= w_sat;
            r_out_active <= ACTIVE_W'(r_active_cnt);
        end
    end

    assign i_in.ready             = (r_state == S_IDLE);
    assign o_out.valid            = r_out_valid;
    assign o_out.sample           = r_out_sample;
    assign o_out.active_harmonics = r_out_active;

endmodule

`default_nettype wire

// ===== dv/tb_harmonic_table_oscillator.sv =====
`default_nettype none

module tb_harmonic_table_oscillator;
    import hto_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_LEN    = DEF_TABLE_LENGTH;
    localparam int HARMS      = DEF_MAX_HARMONICS;
    localparam int FRAC       = DEF_FRACTION_BITS;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 300;
    localparam int ITEMS_PER_SETTING = 42;
    localparam int SETTINGS_RUN      = 12;

    // Index beyond the register file; writes to it must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ACC_MOD     = longint'(TBL_LEN) << FRAC;
    localparam longint unsigned FRAC_MASK   = (64'd1 << FRAC) - 64'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [ACTIVE_W-1:0]        active;
    } osc_result_t;

    // Predicts the summed samples and keeps them until the block returns them.
    class osc_scoreboard;
        logic [FUND_W-1:0]  fund_hz;
        logic [RATE_W-1:0]  rate_hz;
        logic [COUNT_W-1:0] harm_cnt;
        logic [WIDE_W-1:0]  amp_lo, amp_hi, ph_lo, ph_hi;
        longint unsigned    phase_acc[HARMS];
        longint unsigned    phase_inc[HARMS];
        bit                 voice_on[HARMS];
        int unsigned        n_active;
        bit                 reload_due;
        int                 cos_table[TBL_LEN];
        osc_result_t        samples_due[$];
        int unsigned        n_errors;
        int unsigned        n_checked;

        function new();
            longint unsigned t, quad, u, c;
            int mag;
            for (int i = 0; i < TBL_LEN; i++) begin
                t = ((longint'(i) << 32) / TBL_LEN) & 64'hFFFF_FFFF;
                quad = t >> 30;
                u = t & (Q30_ONE - 1);
                c = (quad == 1 || quad == 3) ? quarter_cos(Q30_ONE - u) : quarter_cos(u);
                mag = int'((c * 32767 + (Q30_ONE >> 1)) >> 30);
                cos_table[i] = (quad == 1 || quad == 2) ? -mag : mag;
            end
            fund_hz    = RST_FUNDAMENTAL;
            rate_hz    = RST_SAMPLE_RATE;
            harm_cnt   = RST_HARMONIC_COUNT;
            amp_lo     = RST_AMPLITUDES_LOW;
            amp_hi     = '0;
            ph_lo      = '0;
            ph_hi      = '0;
            for (int k = 0; k < HARMS; k++) begin
                phase_acc[k] = 0;
                phase_inc[k] = 0;
                voice_on[k]  = 0;
            end
            n_active   = 0;
            reload_due = 1;
            n_errors   = 0;
            n_checked  = 0;
        endfunction

        // Truncated Taylor series of cos over a quarter turn, Q30 in and out.
        function longint unsigned quarter_cos(longint unsigned u);
            longint unsigned x, x2, r, term;
            x = (u * HALF_PI_Q30) >> 30;
            x2 = (x * x) >> 30;
            r = Q30_ONE;
            for (int n = 7; n >= 1; n--) begin
                term = ((x2 * r) >> 30) / longint'(2 * n * (2 * n - 1));
                r = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
            end
            return r;
        endfunction

        function logic [15:0] lane16(logic [WIDE_W-1:0] lo, logic [WIDE_W-1:0] hi, int k);
            logic [WIDE_W-1:0] w;
            w = (k < 4) ? lo : hi;
            return w[16 * (k % 4) +: 16];
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [WIDE_W-1:0] data);
            case (idx)
                REG_FUNDAMENTAL:     fund_hz  = data[FUND_W-1:0];
                REG_SAMPLE_RATE:     rate_hz  = data[RATE_W-1:0];
                REG_HARMONIC_COUNT:  harm_cnt = data[COUNT_W-1:0];
                REG_AMPLITUDES_LOW:  amp_lo   = data;
                REG_AMPLITUDES_HIGH: amp_hi   = data;
                REG_PHASES_LOW:      ph_lo    = data;
                REG_PHASES_HIGH:     ph_hi    = data;
                default:             return;
            endcase
            reload_due = 1;
        endfunction

        // Reload phases, steps and the active set from the registers.
        function void reload_voices();
            longint unsigned f, cnt, rate;
            cnt = (harm_cnt > HARMS) ? HARMS : harm_cnt;
            rate = rate_hz;
            n_active = 0;
            for (int k = 0; k < HARMS; k++) begin
                f = longint'(fund_hz) * (k + 1);
                voice_on[k]  = 0;
                phase_acc[k] = 0;
                phase_inc[k] = 0;
                if (k >= cnt || f >= rate / 2 || f > FREQ_LIMIT)
                    continue;
                voice_on[k]  = 1;
                phase_inc[k] = ((f * TBL_LEN) << FRAC) / rate;
                phase_acc[k] = ((longint'(lane16(ph_lo, ph_hi, k)) * TBL_LEN) << FRAC) >> 16;
                n_active++;
            end
        endfunction

        // Work out the sample caused by one accepted item.
        function void note_input(logic restart);
            longint          sum, v0, v1, frac, val, amp, s;
            longint unsigned acc, i0, i1;
            osc_result_t     res;
            if (reload_due || restart) begin
                reload_voices();
                reload_due = 0;
            end
            sum = 0;
            for (int k = 0; k < HARMS; k++) begin
                if (!voice_on[k])
                    continue;
                acc = phase_acc[k];
                i0 = acc >> FRAC;
                i1 = i0 + 1;
                if (i0 >= TBL_LEN)
                    i0 = 0;
                if (i1 >= TBL_LEN)
                    i1 = 0;
                v0 = cos_table[i0];
                v1 = cos_table[i1];
                frac = longint'(acc & FRAC_MASK);
                val = v0 + (((v1 - v0) * frac) >>> FRAC);
                amp = $signed(lane16(amp_lo, amp_hi, k));
                sum += val * amp;
                acc += phase_inc[k];
                if (acc >= ACC_MOD)
                    acc -= ACC_MOD;
                phase_acc[k] = acc;
            end
            s = sum >>> 15;
            if (s > SAMPLE_MAX)
                s = SAMPLE_MAX;
            if (s < SAMPLE_MIN)
                s = SAMPLE_MIN;
            res.sample = s[SAMPLE_W-1:0];
            res.active = n_active[ACTIVE_W-1:0];
            samples_due.push_back(res);
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] smp, logic [ACTIVE_W-1:0] act);
            osc_result_t want;
            if (samples_due.size() == 0) begin
                $display("%0t: sample %0d (active %0d) arrived with none expected",
                         $time, smp, act);
                n_errors++;
                return;
            end
            want = samples_due.pop_front();
            if (smp !== want.sample) begin
                $display("%0t: sample mismatch: expected %0d, actual %0d",
                         $time, want.sample, smp);
                n_errors++;
            end
            if (act !== want.active) begin
                $display("%0t: active_harmonics mismatch: expected %0d, actual %0d",
                         $time, want.active, act);
                n_errors++;
            end
            n_checked++;
        endfunction

        function int outstanding();
            return samples_due.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [WIDE_W-1:0]      cfg_data;

    hto_in_if  in_if ();
    hto_out_if out_if ();

    osc_scoreboard sb = new();

    int src_idle;
    int snk_idle;
    int idle_cycles;
    int n_settings;
    int n_restarts;

    harmonic_table_oscillator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Sink side: the ready line idles at random every cycle.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    // Track every handshake and register write at the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if (out_if.valid && out_if.ready)
                sb.check_result(out_if.sample, out_if.active_harmonics);
            if (in_if.valid && in_if.ready)
                sb.note_input(in_if.restart);
            if (cfg_we || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog on cycles without any progress.
    initial begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Present one item and hold it until the block takes it; returns at a falling edge.
    task automatic send_item(input logic restart);
        while ($urandom_range(99) < src_idle) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.restart <= restart;
        if (restart)
            n_restarts++;
        do
            @(posedge i_clk);
        while (!in_if.ready);
        @(negedge i_clk);
    endtask

    // Write one register once every sample is back; leaves the write enable high.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WIDE_W-1:0] data);
        in_if.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
    endtask

    // Draw a full register setting, leaning toward many audible harmonics.
    task automatic random_setting();
        logic [WIDE_W-1:0] fund, rate, cnt, amps_lo, amps_hi;
        case ($urandom_range(3))
            0: fund = $urandom_range(1, 2500);
            1: fund = $urandom_range(1, 20000);
            2: fund = {$urandom, $urandom};
            default: begin
                case ($urandom_range(3))
                    0: fund = 0;
                    1: fund = 1;
                    2: fund = 20000;
                    default: fund = 32767;
                endcase
            end
        endcase
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(4))
                    0: rate = 8000;
                    1: rate = 44100;
                    2: rate = 48000;
                    3: rate = 96000;
                    default: rate = 192000;
                endcase
            end
            1: rate = $urandom_range(1, 192000);
            2: rate = {$urandom, $urandom};
            default: begin
                case ($urandom_range(3))
                    0: rate = 0;
                    1: rate = 1;
                    2: rate = 262143;
                    default: rate = 2 * (fund & 64'h7FFF);
                endcase
            end
        endcase
        cnt = ($urandom_range(2) == 0) ? 64'd8 : {$urandom, $urandom};
        if ($urandom_range(4) == 0) begin
            amps_lo = {4{16'h7FFF}};
            amps_hi = {4{16'h8000}};
        end else begin
            amps_lo = {$urandom, $urandom};
            amps_hi = {$urandom, $urandom};
        end
        write_reg(REG_FUNDAMENTAL, fund);
        write_reg(REG_SAMPLE_RATE, rate);
        write_reg(REG_HARMONIC_COUNT, cnt);
        write_reg(REG_AMPLITUDES_LOW, amps_lo);
        write_reg(REG_AMPLITUDES_HIGH, amps_hi);
        write_reg(REG_PHASES_LOW, {$urandom, $urandom});
        write_reg(REG_PHASES_HIGH, {$urandom, $urandom});
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, {$urandom, $urandom});
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_if.valid    = 1'b0;
        in_if.restart  = 1'b0;
        src_idle       = 13;
        snk_idle       = 73;
        n_settings     = 0;
        n_restarts     = 0;
        idle_cycles    = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset setting: the first item loads the phases, then a restart.
        repeat (3) send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);

        // Eight harmonics at full-scale amplitudes of both signs, start phases at the top for the first four.
        write_reg(REG_FUNDAMENTAL, 100);
        write_reg(REG_HARMONIC_COUNT, 8);
        write_reg(REG_AMPLITUDES_LOW, {4{16'h7FFF}});
        write_reg(REG_AMPLITUDES_HIGH, {4{16'h8000}});
        write_reg(REG_PHASES_LOW, {4{16'hFFFF}});
        write_reg(REG_PHASES_HIGH, 64'd0);
        cfg_we <= 1'b0;
        repeat (3) send_item(1'b0);

        // A count above the maximum, the highest standard rate, and the fundamental at the audible limit.
        write_reg(REG_HARMONIC_COUNT, 15);
        write_reg(REG_SAMPLE_RATE, 192000);
        write_reg(REG_FUNDAMENTAL, 20000);
        cfg_we <= 1'b0;
        repeat (2) send_item(1'b0);

        // Largest fundamental and rate codes: every harmonic is above the limit.
        write_reg(REG_FUNDAMENTAL, 32767);
        write_reg(REG_SAMPLE_RATE, 262143);
        cfg_we <= 1'b0;
        send_item(1'b0);

        // Sample rates of zero and one skip everything.
        write_reg(REG_FUNDAMENTAL, 100);
        write_reg(REG_SAMPLE_RATE, 0);
        cfg_we <= 1'b0;
        send_item(1'b0);
        write_reg(REG_SAMPLE_RATE, 1);
        cfg_we <= 1'b0;
        send_item(1'b0);

        // A zero fundamental stays active and gives a constant.
        write_reg(REG_FUNDAMENTAL, 0);
        write_reg(REG_SAMPLE_RATE, 48000);
        write_reg(REG_HARMONIC_COUNT, 3);
        cfg_we <= 1'b0;
        repeat (2) send_item(1'b0);

        // No harmonics at all.
        write_reg(REG_HARMONIC_COUNT, 0);
        cfg_we <= 1'b0;
        send_item(1'b0);

        // A write beyond the register file must not disturb the running phases.
        write_reg(REG_FUNDAMENTAL, 1000);
        write_reg(REG_HARMONIC_COUNT, 4);
        cfg_we <= 1'b0;
        send_item(1'b0);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        cfg_we <= 1'b0;
        repeat (2) send_item(1'b0);

        // Random settings, each followed by a run of samples with occasional restarts.
        for (int blk = 0; blk < SETTINGS_RUN; blk++) begin
            case (blk / (SETTINGS_RUN / 3))
                0: begin
                    src_idle = 13;
                    snk_idle = 73;
                end
                1: begin
                    src_idle = 73;
                    snk_idle = 13;
                end
                default: begin
                    src_idle = 0;
                    snk_idle = 0;
                end
            endcase
            random_setting();
            repeat (ITEMS_PER_SETTING)
                send_item($urandom_range(9) == 0);
        end
        in_if.valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Checked %0d samples over %0d random settings plus directed corner settings,",
                 sb.n_checked, n_settings);
        $display("with %0d restarts under three handshake idling profiles.", n_restarts);
        if (sb.n_errors == 0 && sb.outstanding() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d samples never arrived",
                     sb.n_errors, sb.outstanding());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
